>>> rtl/core/ellsms_pkg.sv
`default_nettype none

package ellsms_pkg;

  // Default sizes of the store
  localparam int DEF_MAX_ROWS    = 256;
  localparam int DEF_MAX_SLOTS   = 8;
  localparam int DEF_VALUE_WIDTH = 32;

  // Configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] REG_ROWS  = 2'd0;
  localparam logic [1:0] REG_COLS  = 2'd1;
  localparam logic [1:0] REG_SLOTS = 2'd2;

  localparam logic [8:0] ROWS_RESET  = 9'd256;
  localparam logic [8:0] COLS_RESET  = 9'd256;
  localparam logic [3:0] SLOTS_RESET = 4'd8;
  localparam logic [8:0] COLS_LIMIT  = 9'd256;

  // Operation codes
  localparam logic [2:0] OP_SET      = 3'd0;
  localparam logic [2:0] OP_ADD      = 3'd1;
  localparam logic [2:0] OP_GET      = 3'd2;
  localparam logic [2:0] OP_ZERO_ROW = 3'd3;
  localparam logic [2:0] OP_ZERO_COL = 3'd4;
  localparam logic [2:0] OP_ZERO_ALL = 3'd5;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_MISS  = 2'd3;

  typedef struct packed {
    logic [2:0]         op;
    logic [7:0]         row_index;
    logic [7:0]         col_index;
    logic signed [31:0] data_value;
  } ell_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
  } ell_rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/ell_sparse_matrix_store_unit.sv
// Operation: set, add and get scan the slots of the addressed row from the first, one slot per cycle
//   through the slot memory's registered read, then pass through the finish state to the result.
// Zero column and zero all walk the slots in use over all rows in use; zero row walks its row.
// Throughput: one request at a time; a new request is taken once the last result is loaded out.
// Reset: control and configuration registers return to their reset values, then a clearing pass over
//   all MAX_ROWS*MAX_SLOTS slot entries empties the slot memory; no request is taken until it ends.
`default_nettype none

module ell_sparse_matrix_store_unit #(
  parameter int MAX_ROWS    = ellsms_pkg::DEF_MAX_ROWS,
  parameter int MAX_SLOTS   = ellsms_pkg::DEF_MAX_SLOTS,
  parameter int VALUE_WIDTH = ellsms_pkg::DEF_VALUE_WIDTH
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // request channel
  input  wire logic                              in_valid_i,
  output      logic                              in_stall_o,
  input  wire ellsms_pkg::ell_req_t              in_req_i,
  // result channel
  output      logic                              out_valid_o,
  input  wire logic                              out_stall_i,
  output      ellsms_pkg::ell_rsp_t              out_rsp_o,
  // configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [ellsms_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [ellsms_pkg::CFG_DATA_W-1:0] pwdata,
  output      logic [ellsms_pkg::CFG_DATA_W-1:0] prdata,
  output      logic                              pready
);

  localparam int VW    = VALUE_WIDTH;
  localparam int DEPTH = MAX_ROWS * MAX_SLOTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int SW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int RCW   = $clog2(MAX_ROWS + 1);
  localparam int SCW   = $clog2(MAX_SLOTS + 1);
  localparam int CMPW  = (RW > 8) ? RW : 8;

  // Sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FIN   = 3'd3;

  // ---------------------------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------------------------
  logic [8:0] rows_q, cols_q;
  logic [3:0] slots_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= ellsms_pkg::ROWS_RESET;
      cols_q  <= ellsms_pkg::COLS_RESET;
      slots_q <= ellsms_pkg::SLOTS_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        ellsms_pkg::REG_ROWS:  rows_q  <= pwdata[8:0];
        ellsms_pkg::REG_COLS:  cols_q  <= pwdata[8:0];
        ellsms_pkg::REG_SLOTS: slots_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      ellsms_pkg::REG_ROWS:  prdata = ellsms_pkg::CFG_DATA_W'(rows_q);
      ellsms_pkg::REG_COLS:  prdata = ellsms_pkg::CFG_DATA_W'(cols_q);
      ellsms_pkg::REG_SLOTS: prdata = ellsms_pkg::CFG_DATA_W'(slots_q);
      default:               prdata = '0;
    endcase
  end

  // Clamp each register to what the store can hold
  logic [RCW-1:0] eff_rows;
  logic [8:0]     eff_cols;
  logic [SCW-1:0] eff_slots;

  assign eff_rows  = (32'(rows_q) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(rows_q);
  assign eff_cols  = (cols_q > ellsms_pkg::COLS_LIMIT) ? ellsms_pkg::COLS_LIMIT : cols_q;
  assign eff_slots = (32'(slots_q) > MAX_SLOTS) ? SCW'(MAX_SLOTS) : SCW'(slots_q);

  // ---------------------------------------------------------------------------------------------
  // Value width handling: saturate the request value in, sign-extend or cut the read value out
  // ---------------------------------------------------------------------------------------------
  logic [VW-1:0] in_data_sat;
  logic [VW-1:0] rd_value;
  logic [31:0]   rd_value_ext;

  if (VW < 32) begin : g_narrow
    localparam logic signed [31:0] VMAX = 32'sd2 ** (VW - 1) - 32'sd1;
    localparam logic signed [31:0] VMIN = -VMAX - 32'sd1;
    assign in_data_sat = (in_req_i.data_value > VMAX) ? VMAX[VW-1:0] :
                         (in_req_i.data_value < VMIN) ? VMIN[VW-1:0] :
                         in_req_i.data_value[VW-1:0];
    assign rd_value_ext = {{(32 - VW){rd_value[VW-1]}}, rd_value};
  end else begin : g_wide
    assign in_data_sat  = VW'(in_req_i.data_value);
    assign rd_value_ext = rd_value[31:0];
  end

  // ---------------------------------------------------------------------------------------------
  // Request registers and sequencer
  // ---------------------------------------------------------------------------------------------
  logic [2:0]     state_q, state_d;
  logic [2:0]     op_q;
  logic [RW-1:0]  row_q;
  logic [7:0]     col_q;
  logic [VW-1:0]  data_q;
  logic [RW-1:0]  cur_row_q, nxt_row;
  logic [SW-1:0]  cur_slot_q, nxt_slot;
  logic [AW-1:0]  cur_addr_q, rd_addr;
  logic [AW-1:0]  clr_q;
  logic [1:0]     res_status_q, res_status_d;
  logic [31:0]    res_value_q, res_value_d;
  logic           out_valid_q;
  ellsms_pkg::ell_rsp_t out_q;

  // Memory read data (registered inside the memory block)
  logic           rd_valid;
  logic [7:0]     rd_col_q;
  logic [VW:0]    rd_va_q;

  assign rd_valid = rd_va_q[VW];
  assign rd_value = rd_va_q[VW-1:0];

  // Scan decisions on the slot now returned by the memory
  logic           scan_done;
  logic           slot_last, row_last, hit;
  logic           va_we, col_we;
  logic [VW-1:0]  wr_value;
  logic [VW:0]    sum;
  logic [VW-1:0]  sat_sum;

  assign slot_last = (SCW'(cur_slot_q) + SCW'(1)) == eff_slots;
  assign row_last  = (RCW'(cur_row_q) + RCW'(1)) == eff_rows;
  assign hit       = !rd_valid || (rd_col_q == col_q);

  // Saturating accumulate: overflow shows as disagreeing top bits of the widened sum
  assign sum     = {rd_value[VW-1], rd_value} + {data_q[VW-1], data_q};
  assign sat_sum = (sum[VW] != sum[VW-1]) ? {sum[VW], {(VW - 1){~sum[VW]}}} : sum[VW-1:0];

  always_comb begin
    scan_done    = 1'b0;
    nxt_row      = cur_row_q;
    nxt_slot     = cur_slot_q + SW'(1);
    va_we        = 1'b0;
    col_we       = 1'b0;
    wr_value     = rd_value;
    res_status_d = ellsms_pkg::ST_OK;
    res_value_d  = '0;
    case (op_q)
      ellsms_pkg::OP_SET, ellsms_pkg::OP_ADD, ellsms_pkg::OP_GET: begin
        if (hit) begin
          scan_done = 1'b1;
          if (op_q == ellsms_pkg::OP_GET) begin
            res_value_d = rd_valid ? rd_value_ext : '0;
          end else begin
            // claim an empty slot or update the matching one
            va_we    = 1'b1;
            col_we   = 1'b1;
            wr_value = (op_q == ellsms_pkg::OP_SET || !rd_valid) ? data_q : sat_sum;
          end
        end else if (slot_last) begin
          scan_done    = 1'b1;
          res_status_d = (op_q == ellsms_pkg::OP_GET) ? ellsms_pkg::ST_MISS : ellsms_pkg::ST_FULL;
        end
      end
      ellsms_pkg::OP_ZERO_ROW: begin
        if (!rd_valid) begin
          scan_done = 1'b1;
        end else begin
          va_we     = 1'b1;
          wr_value  = (CMPW'(rd_col_q) == CMPW'(row_q)) ? data_q : '0;
          scan_done = slot_last;
        end
      end
      ellsms_pkg::OP_ZERO_COL, ellsms_pkg::OP_ZERO_ALL: begin
        if (op_q == ellsms_pkg::OP_ZERO_ALL) begin
          va_we    = rd_valid;
          wr_value = '0;
        end else begin
          va_we    = rd_valid && (rd_col_q == col_q);
          wr_value = (CMPW'(cur_row_q) == CMPW'(col_q)) ? data_q : '0;
        end
        // end of row: move on to the next row's first slot
        if (!rd_valid || slot_last) begin
          if (row_last) begin
            scan_done = 1'b1;
          end else begin
            nxt_row  = cur_row_q + RW'(1);
            nxt_slot = '0;
          end
        end
      end
      default: scan_done = 1'b1;
    endcase
  end

  // Immediate outcome of a request, decided at acceptance
  logic           row_bad, col_bad, no_slots, no_rows;
  logic           go_scan;
  logic [1:0]     imm_status;

  assign row_bad  = 32'(in_req_i.row_index) >= 32'(eff_rows);
  assign col_bad  = {1'b0, in_req_i.col_index} >= eff_cols;
  assign no_slots = eff_slots == '0;
  assign no_rows  = eff_rows == '0;

  always_comb begin
    go_scan    = 1'b0;
    imm_status = ellsms_pkg::ST_OK;
    case (in_req_i.op)
      ellsms_pkg::OP_SET, ellsms_pkg::OP_ADD, ellsms_pkg::OP_GET: begin
        if (row_bad || col_bad) begin
          imm_status = ellsms_pkg::ST_RANGE;
        end else if (no_slots) begin
          imm_status = (in_req_i.op == ellsms_pkg::OP_GET) ? ellsms_pkg::ST_MISS
                                                            : ellsms_pkg::ST_FULL;
        end else begin
          go_scan = 1'b1;
        end
      end
      ellsms_pkg::OP_ZERO_ROW: begin
        if (row_bad) imm_status = ellsms_pkg::ST_RANGE;
        else         go_scan    = !no_slots;
      end
      ellsms_pkg::OP_ZERO_COL: begin
        if (col_bad) imm_status = ellsms_pkg::ST_RANGE;
        else         go_scan    = !no_slots && !no_rows;
      end
      ellsms_pkg::OP_ZERO_ALL: go_scan = !no_slots && !no_rows;
      default: ;
    endcase
  end

  // First row walked: the addressed row, or row zero for the whole-matrix walks
  logic          walk_all;
  logic [RW-1:0] start_row;

  assign walk_all  = (in_req_i.op == ellsms_pkg::OP_ZERO_COL) ||
                     (in_req_i.op == ellsms_pkg::OP_ZERO_ALL);
  assign start_row = walk_all ? '0 : RW'(in_req_i.row_index);

  // Read address: the slot after the one being evaluated while scanning, else the start row's first slot
  always_comb begin
    if (state_q == S_SCAN) rd_addr = AW'(nxt_row) * AW'(MAX_SLOTS) + AW'(nxt_slot);
    else                   rd_addr = AW'(start_row) * AW'(MAX_SLOTS);
  end

  logic accept, out_free;

  assign in_stall_o = state_q != S_IDLE;
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == AW'(DEPTH - 1)) state_d = S_IDLE;
      S_IDLE:  if (accept) state_d = go_scan ? S_SCAN : S_FIN;
      S_SCAN:  if (scan_done) state_d = S_FIN;
      S_FIN:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + AW'(1);
      // hold the result until taken; load a fresh one from the finish state
      if (state_q == S_FIN && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i)            out_valid_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_addr_q <= rd_addr;
    if (accept) begin
      op_q         <= in_req_i.op;
      row_q        <= RW'(in_req_i.row_index);
      col_q        <= in_req_i.col_index;
      data_q       <= in_data_sat;
      cur_row_q    <= start_row;
      cur_slot_q   <= '0;
      res_status_q <= imm_status;
      res_value_q  <= '0;
    end else if (state_q == S_SCAN) begin
      cur_row_q  <= nxt_row;
      cur_slot_q <= nxt_slot;
      if (scan_done) begin
        res_status_q <= res_status_d;
        res_value_q  <= res_value_d;
      end
    end
    if (state_q == S_FIN && out_free) begin
      out_q.status     <= res_status_q;
      out_q.read_value <= res_value_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // ---------------------------------------------------------------------------------------------
  // Slot memories: valid and value together (cleared after reset), column apart (never cleared)
  // ---------------------------------------------------------------------------------------------
  logic [VW:0]   mem_va [DEPTH];
  logic [7:0]    mem_col [DEPTH];
  logic          va_wen;
  logic [AW-1:0] va_waddr;
  logic [VW:0]   va_wdata;

  assign va_wen   = (state_q == S_CLEAR) || (state_q == S_SCAN && va_we);
  assign va_waddr = (state_q == S_CLEAR) ? clr_q : cur_addr_q;
  assign va_wdata = (state_q == S_CLEAR) ? '0 : {1'b1, wr_value};

  always_ff @(posedge clk_i) begin
    if (va_wen) mem_va[va_waddr] <= va_wdata;
    if (state_q == S_SCAN && col_we) mem_col[cur_addr_q] <= col_q;
    rd_va_q  <= mem_va[rd_addr];
    rd_col_q <= mem_col[rd_addr];
  end

endmodule

`default_nettype wire
